[rtl/crcl_pkg.sv]
// crcl_pkg: shared types and constants for the current reference circle limit
// depends on nothing; used by crcl_mul, crcl_div and current_reference_circle_limit
package crcl_pkg;

    localparam int MUL_W     = 16;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_CNT_W = $clog2(MUL_W);

    localparam int DVD_W     = 31;
    localparam int DVS_W     = 32;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 3;

    localparam logic [DVS_W-1:0]  Q15_ONE     = 32'd32767;
    localparam logic [DVD_W-1:0]  SEED_SPLIT  = 31'd2097152;
    localparam logic [DVS_W-1:0]  SEED_SMALL  = 32'd128;
    localparam logic [DVS_W-1:0]  SEED_LARGE  = 32'd8192;
    localparam logic [STEP_W-1:0] NEWTON_LAST = 3'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_RATIO     = 2'd1,
        REG_MAX_SQ    = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_ID_GO,
        S_MUL_ID,
        S_DIV_ID_GO,
        S_DIV_ID,
        S_SQ_GO,
        S_SQ,
        S_ROOT_CHECK,
        S_NEWTON_GO,
        S_NEWTON,
        S_FINISH
    } state_t;

endpackage

[rtl/crcl_mul.sv]
// crcl_mul: bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
// depends on crcl_pkg
module crcl_mul
    import crcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic              done,
    output logic [PROD_W-1:0] product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [PROD_W-1:0]    mcand_reg, mcand_next;
    logic [MUL_W-1:0]     mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            acc_next    = '0;
            mcand_next  = {{(PROD_W-MUL_W){1'b0}}, a};
            mplier_next = b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/crcl_div.sv]
// crcl_div: radix-2 restoring divider, one quotient bit per cycle
// depends on crcl_pkg
module crcl_div
    import crcl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W+1:0]     trial;

    assign trial = {1'b0, rem_reg, quo_reg[DVD_W-1]} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial[DVS_W+1])
            begin
                rem_next = {rem_reg[DVS_W-2:0], quo_reg[DVD_W-1]};
            end
            else
            begin
                rem_next = trial[DVS_W-1:0];
            end
            quo_next = {quo_reg[DVD_W-2:0], ~trial[DVS_W+1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/current_reference_circle_limit.sv]
// current_reference_circle_limit: d injection and q clamping to the current circle
// depends on crcl_pkg, crcl_mul, crcl_div
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    iq_request, speed
// out      out        out_valid / out_ready  iq_ref, id_ref
//
// one item at a time: a beat whose circle argument is not positive skips the newton root;
// otherwise up to six newton steps run before the result, then the block returns to idle
// the serial divider dominates the work: one quotient per division, up to seven quotients
// the product and the square each run on the serial multiplier
// the output register lets the next beat in while a result waits for out_ready
// cfg_ready is always high; state, out_valid and config registers reset to zero, datapath has no reset
module current_reference_circle_limit
    import crcl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   iq_request,
    input  logic signed [31:0]   speed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [15:0]   iq_ref,
    output logic signed [15:0]   id_ref
);

    state_t state_reg, state_next;

    logic signed [31:0] thr_reg;
    logic [14:0]        ratio_reg;
    logic [30:0]        max_sq_reg;

    logic signed [15:0] iq_reg, iq_next;
    logic               neg_reg, neg_next;
    logic [MUL_W-1:0]   iq_mag_reg, iq_mag_next;
    logic [14:0]        ratio_sel_reg, ratio_sel_next;
    logic [MUL_W-1:0]   id_mag_reg, id_mag_next;
    logic signed [15:0] id_reg, id_next;
    logic signed [32:0] x_reg, x_next;
    logic [DVS_W-1:0]   r_reg, r_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DVS_W-1:0]   lim_reg, lim_next;

    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] iq_ref_reg, iq_ref_next;
    logic signed [15:0] id_ref_reg, id_ref_next;

    logic              mul_start, mul_done;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_prod;
    logic              div_start, div_done;
    logic [DVD_W-1:0]  div_dvd, div_quo;
    logic [DVS_W-1:0]  div_dvs;
    logic              load_out;

    logic               x_nonpos;
    logic [DVS_W:0]     newton_sum;
    logic [DVS_W-1:0]   newton_r;
    logic               newton_stop;
    logic signed [33:0] iq_ext, lim_ext, lim_neg;

    crcl_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    crcl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign mul_a   = (state_reg == S_MUL_ID_GO) ? iq_mag_reg : id_mag_reg;
    assign mul_b   = (state_reg == S_MUL_ID_GO) ? {1'b0, ratio_sel_reg} : id_mag_reg;
    assign div_dvd = (state_reg == S_DIV_ID_GO) ? mul_prod[DVD_W-1:0] : x_reg[DVD_W-1:0];
    assign div_dvs = (state_reg == S_DIV_ID_GO) ? Q15_ONE : r_reg;

    assign x_nonpos    = x_reg[32] || (x_reg == '0);
    assign newton_sum  = {1'b0, r_reg} + {2'b00, div_quo};
    assign newton_r    = newton_sum[DVS_W:1];
    assign newton_stop = (newton_r == r_reg) || (step_reg == NEWTON_LAST);

    assign iq_ext  = {{18{iq_reg[15]}}, iq_reg};
    assign lim_ext = {2'b00, lim_reg};
    assign lim_neg = -lim_ext;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL_ID_GO;
                end
            end
            S_MUL_ID_GO:  state_next = S_MUL_ID;
            S_MUL_ID:
            begin
                if (mul_done)
                begin
                    state_next = S_DIV_ID_GO;
                end
            end
            S_DIV_ID_GO:  state_next = S_DIV_ID;
            S_DIV_ID:
            begin
                if (div_done)
                begin
                    state_next = S_SQ_GO;
                end
            end
            S_SQ_GO:      state_next = S_SQ;
            S_SQ:
            begin
                if (mul_done)
                begin
                    state_next = S_ROOT_CHECK;
                end
            end
            S_ROOT_CHECK: state_next = x_nonpos ? S_FINISH : S_NEWTON_GO;
            S_NEWTON_GO:  state_next = S_NEWTON;
            S_NEWTON:
            begin
                if (div_done)
                begin
                    state_next = newton_stop ? S_FINISH : S_NEWTON_GO;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            S_IDLE:      in_ready  = 1'b1;
            S_MUL_ID_GO: mul_start = 1'b1;
            S_SQ_GO:     mul_start = 1'b1;
            S_DIV_ID_GO: div_start = 1'b1;
            S_NEWTON_GO: div_start = 1'b1;
            S_FINISH:    load_out  = !out_valid_reg || out_ready;
            default:     in_ready  = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        iq_next        = iq_reg;
        neg_next       = neg_reg;
        iq_mag_next    = iq_mag_reg;
        ratio_sel_next = ratio_sel_reg;
        id_mag_next    = id_mag_reg;
        id_next        = id_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        step_next      = step_reg;
        lim_next       = lim_reg;
        iq_ref_next    = iq_ref_reg;
        id_ref_next    = id_ref_reg;
        out_valid_next = out_valid_reg;

        if (in_ready && in_valid)
        begin
            iq_next        = iq_request;
            neg_next       = iq_request[15];
            iq_mag_next    = iq_request[15] ? MUL_W'(-iq_request) : MUL_W'(iq_request);
            ratio_sel_next = (speed < thr_reg) ? ratio_reg : '0;
        end

        if ((state_reg == S_DIV_ID) && div_done)
        begin
            id_mag_next = div_quo[MUL_W-1:0];
            id_next     = neg_reg ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
        end

        if ((state_reg == S_SQ) && mul_done)
        begin
            x_next = $signed({2'b00, max_sq_reg}) - $signed({1'b0, mul_prod});
        end

        if (state_reg == S_ROOT_CHECK)
        begin
            step_next = '0;
            if (x_nonpos)
            begin
                lim_next = '0;
            end
            else
            begin
                r_next = (x_reg[DVD_W-1:0] <= SEED_SPLIT) ? SEED_SMALL : SEED_LARGE;
            end
        end

        if ((state_reg == S_NEWTON) && div_done)
        begin
            if (newton_stop)
            begin
                lim_next = newton_r;
            end
            else
            begin
                r_next    = newton_r;
                step_next = step_reg + 1'b1;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
            id_ref_next    = id_reg;
            if (iq_ext > lim_ext)
            begin
                iq_ref_next = $signed(lim_reg[15:0]);
            end
            else if (iq_ext < lim_neg)
            begin
                iq_ref_next = lim_neg[15:0];
            end
            else
            begin
                iq_ref_next = iq_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            thr_reg       <= '0;
            ratio_reg     <= '0;
            max_sq_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr_reg    <= $signed(cfg_data);
                    REG_RATIO:     ratio_reg  <= cfg_data[14:0];
                    REG_MAX_SQ:    max_sq_reg <= cfg_data[30:0];
                    default:       thr_reg    <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iq_reg        <= iq_next;
        neg_reg       <= neg_next;
        iq_mag_reg    <= iq_mag_next;
        ratio_sel_reg <= ratio_sel_next;
        id_mag_reg    <= id_mag_next;
        id_reg        <= id_next;
        x_reg         <= x_next;
        r_reg         <= r_next;
        step_reg      <= step_next;
        lim_reg       <= lim_next;
        iq_ref_reg    <= iq_ref_next;
        id_ref_reg    <= id_ref_next;
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign iq_ref    = iq_ref_reg;
    assign id_ref    = id_ref_reg;

endmodule
